[sv/rrva_pkg.sv]
package rrva_pkg;

   localparam int MAX_VOICES_DEF = 8;

   localparam int REQ_TYPE_W = 3;
   localparam int SLOT_IDX_W = 3;
   localparam int NOTE_W     = 7;
   localparam int COUNT_W    = 4;

   localparam logic [REQ_TYPE_W-1:0] REQ_NEXT     = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ACTIVATE = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_FIND     = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY    = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR    = 3'd5;

   typedef struct packed {
      logic [SLOT_IDX_W-1:0] slot_result;
      logic                  found;
      logic                  slot_is_active;
      logic [NOTE_W-1:0]     slot_note;
   } rsp_type;

endpackage

[sv/rrva_if.sv]
interface rrva_req_if import rrva_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [SLOT_IDX_W-1:0] slot_index;
   logic [NOTE_W-1:0]     note_number;

   modport source (output valid, req_type, slot_index, note_number, input ready);
   modport sink   (input valid, req_type, slot_index, note_number, output ready);
endinterface

interface rrva_rsp_if import rrva_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SLOT_IDX_W-1:0] slot_result;
   logic                  found;
   logic                  slot_is_active;
   logic [NOTE_W-1:0]     slot_note;

   modport source (output valid, slot_result, found, slot_is_active, slot_note, input ready);
   modport sink   (input valid, slot_result, found, slot_is_active, slot_note, output ready);
endinterface

interface rrva_csr_if import rrva_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] voice_count;

   modport source (output valid, voice_count, input ready);
   modport sink   (input valid, voice_count, output ready);
endinterface

[sv/rrva_ram.sv]
module rrva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/round_robin_voice_allocator_unit.sv]
// Channel   Dir  Payload                                          Handshake
// req_chan  in   req_type, slot_index, note_number                valid/ready
// rsp_chan  out  slot_result, found, slot_is_active, slot_note    valid/ready
// csr_chan  in   voice_count (saturated to 1..MAX_VOICES)         valid/ready
//
// One item at a time. Next, activate, release and clear pass through the exec and
// done states to the output register; query adds a wait state for the note memory
// read; find scans up to voice_count slots, one compared per cycle via the read port.
// req ready only while idle; it returns once the result enters the output
// register, so a stalled rsp holds back at most one further item.
// Synchronous reset clears head, active and written flags at once; csr always ready.
module round_robin_voice_allocator_unit import rrva_pkg::*; #(
   parameter int MAX_VOICES = MAX_VOICES_DEF
) (
   input  logic  clock,
   input  logic  reset,
   rrva_req_if.sink   req_chan,
   rrva_rsp_if.source rsp_chan,
   rrva_csr_if.sink   csr_chan
);

   localparam int SLOT_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CNT_W  = $clog2(MAX_VOICES + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_QWAIT = 5'b00100,
      S_SCAN  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SLOT_W-1:0]      head_ff, head_in;
   logic [MAX_VOICES-1:0]  active_ff, active_in;
   logic [MAX_VOICES-1:0]  written_ff, written_in;
   logic [REQ_TYPE_W-1:0]  req_type_ff, req_type_in;
   logic [SLOT_IDX_W-1:0]  slot_ff, slot_in;
   logic [NOTE_W-1:0]      note_ff, note_in;
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic                   pend_ff, pend_in;
   logic [SLOT_W-1:0]      pend_idx_ff, pend_idx_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [SLOT_W-1:0]      slot_ix;
   logic                   slot_ok;
   logic                   ram_we;
   logic [SLOT_W-1:0]      ram_raddr;
   logic [NOTE_W-1:0]      ram_rdata;
   logic [CNT_W-1:0]       count_sat;
   int                     head_plus;

   rrva_ram #(
      .WIDTH (NOTE_W),
      .DEPTH (MAX_VOICES)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ix),
      .wr_data (note_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign slot_ix   = SLOT_W'(slot_ff);
   assign slot_ok   = 32'(slot_ff) < MAX_VOICES;
   assign ram_we    = (state_ff == S_EXEC) && (req_type_ff == REQ_ACTIVATE) && slot_ok;
   assign ram_raddr = (state_ff == S_EXEC) ? slot_ix : issue_ff[SLOT_W-1:0];
   assign head_plus = 32'(head_ff) + 1;

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.slot_result    = rsp_ff.slot_result;
   assign rsp_chan.found          = rsp_ff.found;
   assign rsp_chan.slot_is_active = rsp_ff.slot_is_active;
   assign rsp_chan.slot_note      = rsp_ff.slot_note;

   always_comb begin
      if (csr_chan.voice_count == '0) begin
         count_sat = CNT_W'(1);
      end else if (32'(csr_chan.voice_count) > MAX_VOICES) begin
         count_sat = CNT_W'(MAX_VOICES);
      end else begin
         count_sat = CNT_W'(csr_chan.voice_count);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      active_in    = active_ff;
      written_in   = written_ff;
      req_type_in  = req_type_ff;
      slot_in      = slot_ff;
      note_in      = note_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_chan.valid) begin
         count_in = count_sat;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               req_type_in = req_chan.req_type;
               slot_in     = req_chan.slot_index;
               note_in     = req_chan.note_number;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in   = '0;
            state_in = S_DONE;
            case (req_type_ff)
               REQ_NEXT: begin
                  res_in.slot_result = SLOT_IDX_W'(head_ff);
                  head_in = (head_plus < 32'(count_ff)) ? SLOT_W'(head_plus) : '0;
               end
               REQ_ACTIVATE: begin
                  if (slot_ok) begin
                     active_in[slot_ix]  = 1'b1;
                     written_in[slot_ix] = 1'b1;
                  end
               end
               REQ_FIND: begin
                  issue_in = '0;
                  pend_in  = 1'b0;
                  state_in = S_SCAN;
               end
               REQ_RELEASE: begin
                  if (slot_ok) begin
                     active_in[slot_ix] = 1'b0;
                  end
               end
               REQ_QUERY: begin
                  state_in = S_QWAIT;
               end
               REQ_CLEAR: begin
                  head_in    = '0;
                  active_in  = '0;
                  written_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_QWAIT: begin
            if (slot_ok) begin
               res_in.slot_is_active = active_ff[slot_ix];
               res_in.slot_note      = written_ff[slot_ix] ? ram_rdata : '0;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            // reads issue one slot ahead of the compare
            if (issue_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[SLOT_W-1:0];
               issue_in    = issue_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && active_ff[pend_idx_ff] && (ram_rdata == note_ff)) begin
               res_in.slot_result = SLOT_IDX_W'(pend_idx_ff);
               res_in.found       = 1'b1;
               pend_in            = 1'b0;
               state_in           = S_DONE;
            end else if (!pend_ff && !(issue_ff < count_ff)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         head_ff      <= '0;
         active_ff    <= '0;
         written_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         active_ff    <= active_in;
         written_ff   <= written_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      slot_ff     <= slot_in;
      note_ff     <= note_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (32'(count_ff) <= MAX_VOICES))
      else $error("voice count out of range");

   a_active_written: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~written_ff) == '0)
      else $error("active slot without a stored note");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && pend_ff |-> 32'(pend_idx_ff) < 32'(count_ff))
      else $error("find compares a slot beyond the voice count");

   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready) |=> rsp_valid_ff)
      else $error("finished item did not reach the output register");

endmodule
